/* rtl/core/usr_pkg.sv */
// Shared types, constants and helpers for the UTF-8 sanitizer.
// No dependencies; used by the top level.
package usr_pkg;

  localparam logic [7:0] REPL0 = 8'hEF;
  localparam logic [7:0] REPL1 = 8'hBF;
  localparam logic [7:0] REPL2 = 8'hBD;

  localparam logic [7:0] MASK2 = 8'hE0;
  localparam logic [7:0] MASK3 = 8'hF0;
  localparam logic [7:0] MASK4 = 8'hF8;
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_VAL  = 8'h80;

  localparam int HELD_DEPTH = 3;
  localparam int SLOTS      = 4;

  // One item's output: up to four units, each a literal byte or a replacement triple
  typedef struct packed {
    logic [SLOTS-1:0]      rep;
    logic [SLOTS-1:0][7:0] lit;
    logic [2:0]            n;
    logic                  last_in;
  } job_t;

  // Announced sequence length: 1 for ASCII, 2..4 for leads, 0 for invalid
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (!b[7])                    len = 3'd1;
    else if ((b & MASK2) == LEAD2) len = 3'd2;
    else if ((b & MASK3) == LEAD3) len = 3'd3;
    else if ((b & MASK4) == LEAD4) len = 3'd4;
    return len;
  endfunction

endpackage

/* rtl/core/usr_if.sv */
// Valid/ready channel interfaces for the UTF-8 sanitizer.
// Standalone; carries the raw byte in and the sanitized byte out.
interface usr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface usr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_last;

  modport source (output valid, output out_byte, output run_last, output stream_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_last,
                  output ready);
endinterface

/* rtl/core/utf8_sanitize_replace_invalid_unit.sv */
// UTF-8 sanitizer: one raw byte per item in, one sanitized byte out per ready cycle.
// Depends on usr_pkg and the channel interfaces in usr_if.sv.
//
// An item is taken every cycle as long as each item yields at most one output byte
// and the sink keeps up. An item that yields k bytes (a completed sequence of up to
// four bytes, or up to four EF BF BD replacements, the last may be a literal byte,
// at most 12 bytes) holds the output port until all k are emitted, as the port
// sends one byte per cycle while the sink is ready. Sequence state is updated when
// an item is accepted; its output plan then sits in a one-entry holding register
// ahead of the output register, so the next item is taken while the current plan
// is still being emitted. Items that only extend a held sequence produce no output.
module utf8_sanitize_replace_invalid_unit (
  input  logic            clk,
  input  logic            rst_n,
  usr_in_if.sink          in_ch,
  usr_out_if.source       out_ch
);

  // sequence state
  logic [usr_pkg::HELD_DEPTH-1:0][7:0] held_r, held_nxt;
  logic [1:0] held_count_r, held_count_nxt;
  logic [2:0] seq_len_r, seq_len_nxt;

  // plan holding stage and output stage
  usr_pkg::job_t job_nxt, a_job_r, b_job_r;
  logic a_valid_r, b_valid_r;
  logic [1:0] b_slot_r, b_sub_r;

  logic in_fire, out_fire, slot_done, job_done, a_to_b;
  logic is_cont, do_fresh, is_end;
  logic [1:0] cnt, fs;
  logic [2:0] llen;
  logic [7:0] b;
  logic [7:0] cur_byte;

  // holding stage frees up in the same cycle its plan moves to the output stage
  assign in_ch.ready = !a_valid_r || a_to_b;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign is_end      = in_ch.stream_end;
  assign is_cont     = (b & usr_pkg::CONT_MASK) == usr_pkg::CONT_VAL;
  assign llen        = usr_pkg::lead_len(b);
  assign cnt         = held_count_r;

  // Plan and next sequence state for the byte on the input
  always_comb begin
    job_nxt        = '0;
    job_nxt.last_in = is_end;
    held_nxt       = held_r;
    held_count_nxt = held_count_r;
    seq_len_nxt    = seq_len_r;
    do_fresh       = 1'b0;
    fs             = 2'd0;
    if (cnt == 2'd0) begin
      do_fresh = 1'b1;
    end else if (is_cont) begin
      if ({1'b0, cnt} + 3'd1 == seq_len_r) begin
        for (int i = 0; i < usr_pkg::HELD_DEPTH; i++) begin
          if (i < cnt) job_nxt.lit[i] = held_r[i];
        end
        job_nxt.lit[cnt] = b;
        job_nxt.n        = {1'b0, cnt} + 3'd1;
        held_count_nxt   = 2'd0;
        seq_len_nxt      = 3'd0;
      end else if (is_end || cnt == 2'd3) begin
        for (int i = 0; i < usr_pkg::SLOTS; i++) begin
          if (i <= cnt) job_nxt.rep[i] = 1'b1;
        end
        job_nxt.n      = {1'b0, cnt} + 3'd1;
        held_count_nxt = 2'd0;
        seq_len_nxt    = 3'd0;
      end else begin
        held_nxt[cnt]  = b;
        held_count_nxt = cnt + 2'd1;
      end
    end else begin
      // sequence broken: every held byte is replaced, then the byte starts over
      for (int i = 0; i < usr_pkg::HELD_DEPTH; i++) begin
        if (i < cnt) job_nxt.rep[i] = 1'b1;
      end
      job_nxt.n      = {1'b0, cnt};
      held_count_nxt = 2'd0;
      seq_len_nxt    = 3'd0;
      do_fresh       = 1'b1;
      fs             = cnt;
    end

    if (do_fresh) begin
      if (llen == 3'd1) begin
        job_nxt.lit[fs] = b;
        job_nxt.n       = {1'b0, fs} + 3'd1;
      end else if (llen == 3'd0 || is_end) begin
        job_nxt.rep[fs] = 1'b1;
        job_nxt.n       = {1'b0, fs} + 3'd1;
      end else begin
        held_nxt[0]    = b;
        held_count_nxt = 2'd1;
        seq_len_nxt    = llen;
      end
    end
  end

  // Output stage: walk the units of the plan, three bytes for a replacement
  always_comb begin
    case (b_sub_r)
      2'd0:    cur_byte = b_job_r.rep[b_slot_r] ? usr_pkg::REPL0 : b_job_r.lit[b_slot_r];
      2'd1:    cur_byte = usr_pkg::REPL1;
      2'd2:    cur_byte = usr_pkg::REPL2;
      default: cur_byte = usr_pkg::REPL2;
    endcase
  end

  assign slot_done = !b_job_r.rep[b_slot_r] || b_sub_r == 2'd2;
  assign job_done  = slot_done && ({1'b0, b_slot_r} + 3'd1 == b_job_r.n);
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign a_to_b    = a_valid_r && (!b_valid_r || (out_fire && job_done));

  assign out_ch.valid       = b_valid_r;
  assign out_ch.out_byte    = cur_byte;
  assign out_ch.run_last    = job_done;
  assign out_ch.stream_last = job_done && b_job_r.last_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= 2'd0;
      seq_len_r    <= 3'd0;
      a_valid_r    <= 1'b0;
      b_valid_r    <= 1'b0;
      b_slot_r     <= 2'd0;
      b_sub_r      <= 2'd0;
    end else begin
      if (in_fire) begin
        held_count_r <= held_count_nxt;
        seq_len_r    <= seq_len_nxt;
      end
      if (a_to_b) begin
        a_valid_r <= 1'b0;
      end
      // items that only extend a held sequence produce nothing to emit
      if (in_fire && job_nxt.n != 3'd0) begin
        a_valid_r <= 1'b1;
      end
      if (a_to_b) begin
        b_valid_r <= 1'b1;
        b_slot_r  <= 2'd0;
        b_sub_r   <= 2'd0;
      end else if (out_fire) begin
        if (job_done) begin
          b_valid_r <= 1'b0;
          b_slot_r  <= 2'd0;
          b_sub_r   <= 2'd0;
        end else if (slot_done) begin
          b_slot_r <= b_slot_r + 2'd1;
          b_sub_r  <= 2'd0;
        end else begin
          b_sub_r <= b_sub_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r  <= held_nxt;
      a_job_r <= job_nxt;
    end
    if (a_to_b) begin
      b_job_r <= a_job_r;
    end
  end

  a_held_len: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r != 2'd0 |-> seq_len_r > {1'b0, held_count_r})
    else $error("held count not below announced sequence length");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> ({1'b0, b_slot_r} < b_job_r.n))
    else $error("output unit index past end of plan");

  a_sub_literal: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !b_job_r.rep[b_slot_r] |-> b_sub_r == 2'd0)
    else $error("byte counter advanced inside a literal unit");

  a_no_empty_plan: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> a_job_r.n != 3'd0)
    else $error("empty plan held for output");

endmodule
